// ===== hdl/ordered_list_engine_macros.svh =====
// Assertion macros shared by the ordered list engine RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ole_pkg.sv =====
// Package for the ordered list engine: field widths, action and status codes.
// Used by ole_store and ordered_list_engine; depends on nothing else.
package ole_pkg;

  // Default list capacity.
  localparam int CAPACITY_DEF = 16;

  // Field widths of one input beat and one result beat.
  localparam int ACTION_W = 3;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Bus widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR   = 3'd0,
    ACT_INSERT  = 3'd1,
    ACT_DEL_POS = 3'd2,
    ACT_DEL_VAL = 3'd3,
    ACT_READ    = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

endpackage

// ===== hdl/ole_store.sv =====
// Element store of the ordered list engine: one write port, one registered read port.
// Depends on ole_pkg for the element width.
module ole_store
  import ole_pkg::*;
#(
  parameter int DEPTH = CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [VALUE_W-1:0]         wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [VALUE_W-1:0]         rd_data
);

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/ordered_list_engine.sv =====
// Ordered list engine: a list of up to CAPACITY signed 32-bit values held in a store with one
// write port and one registered read port, addressed by 1-based position. One beat is taken at
// a time; in_tready is high only while the engine is idle. An insert or a delete at position
// shifts the entries behind it one at a time; a delete by value first searches the list from
// its head for the match and reports not found if there is none; a read-out sends one result
// beat per element. Clear, full, empty, unused-action and position-not-found cases send a single
// result beat. Result beats wait while the sink holds out_tready low. No clearing pass follows
// reset.
`include "ordered_list_engine_macros.svh"

module ordered_list_engine
  import ole_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // action[2:0], position[7:3], value[39:8]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // status[1:0], element[33:2], count[38:34], 0
  output logic                   out_tlast
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE,
    S_SEARCH,
    S_RD_LOAD,
    S_OUT
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      cur_r, cur_nxt;
  logic [CW-1:0]      left_r, left_nxt;
  logic               ins_r, ins_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic [AW-1:0]      pend_a_r, pend_a_nxt;
  logic               cmp_v_r, cmp_v_nxt;
  logic [AW-1:0]      cmp_a_r, cmp_a_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [VALUE_W-1:0] out_elem_r, out_elem_nxt;
  logic               out_last_r, out_last_nxt;

  logic               wr_en, rd_en;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [VALUE_W-1:0] wr_data, rd_data;

  logic [ACTION_W-1:0] in_action;
  logic [POS_W-1:0]    in_pos;
  logic [VALUE_W-1:0]  in_value;
  logic [EW-1:0]       pos_e, count_e, ins_idx_e;
  logic                in_fire;

  // Unpack the input beat.
  assign in_action = in_tdata[ACTION_W-1:0];
  assign in_pos    = in_tdata[ACTION_W+POS_W-1:ACTION_W];
  assign in_value  = in_tdata[ACTION_W+POS_W+VALUE_W-1:ACTION_W+POS_W];
  assign in_fire   = in_tvalid && in_tready;

  // Position arithmetic in a width that holds both the position and the count.
  assign pos_e   = EW'(in_pos);
  assign count_e = EW'(count_r);
  always_comb begin
    ins_idx_e = (pos_e == '0) ? '0 : pos_e - EW'(1);
    if (ins_idx_e > count_e) begin
      ins_idx_e = count_e;
    end
  end

  ole_store #(
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer: decodes an action, then moves or searches one store entry per cycle.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    cur_nxt        = cur_r;
    left_nxt       = left_r;
    ins_nxt        = ins_r;
    pend_v_nxt     = pend_v_r;
    pend_a_nxt     = pend_a_r;
    cmp_v_nxt      = cmp_v_r;
    cmp_a_nxt      = cmp_a_r;
    idx_nxt        = idx_r;
    val_nxt        = val_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_elem_nxt   = out_elem_r;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    wr_addr        = pend_a_r;
    wr_data        = rd_data;
    rd_en          = 1'b0;
    rd_addr        = cur_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        // Single-beat results default to a final beat with no element.
        out_elem_nxt = '0;
        out_last_nxt = 1'b1;
        if (in_fire) begin
          unique case (action_t'(in_action))
            ACT_CLEAR: begin
              count_nxt      = '0;
              out_status_nxt = ST_OK;
              out_valid_nxt  = 1'b1;
              state_nxt      = S_OUT;
            end
            ACT_INSERT: begin
              if (count_r == CW'(CAPACITY)) begin
                out_status_nxt = ST_FULL;
                out_valid_nxt  = 1'b1;
                state_nxt      = S_OUT;
              end else begin
                idx_nxt    = AW'(ins_idx_e);
                val_nxt    = in_value;
                left_nxt   = CW'(count_e - ins_idx_e);
                cur_nxt    = count_r - CW'(1);
                ins_nxt    = 1'b1;
                pend_v_nxt = 1'b0;
                state_nxt  = S_MOVE;
              end
            end
            ACT_DEL_POS: begin
              if (count_r == '0) begin
                out_status_nxt = ST_EMPTY;
                out_valid_nxt  = 1'b1;
                state_nxt      = S_OUT;
              end else if (pos_e == '0 || pos_e > count_e) begin
                out_status_nxt = ST_NOT_FOUND;
                out_valid_nxt  = 1'b1;
                state_nxt      = S_OUT;
              end else begin
                left_nxt   = CW'(count_e - pos_e);
                cur_nxt    = CW'(pos_e);
                ins_nxt    = 1'b0;
                pend_v_nxt = 1'b0;
                state_nxt  = S_MOVE;
              end
            end
            ACT_DEL_VAL: begin
              if (count_r == '0) begin
                out_status_nxt = ST_EMPTY;
                out_valid_nxt  = 1'b1;
                state_nxt      = S_OUT;
              end else begin
                val_nxt   = in_value;
                cur_nxt   = '0;
                cmp_v_nxt = 1'b0;
                state_nxt = S_SEARCH;
              end
            end
            ACT_READ: begin
              if (count_r == '0) begin
                out_status_nxt = ST_EMPTY;
                out_valid_nxt  = 1'b1;
                state_nxt      = S_OUT;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                cur_nxt   = '0;
                state_nxt = S_RD_LOAD;
              end
            end
            default: begin
              out_status_nxt = ST_OK;
              out_valid_nxt  = 1'b1;
              state_nxt      = S_OUT;
            end
          endcase
        end
      end

      S_MOVE: begin
        // Write the entry read last cycle one place up or down, while reading the next one.
        if (pend_v_r) begin
          wr_en = 1'b1;
        end
        if (left_r != '0) begin
          rd_en      = 1'b1;
          pend_v_nxt = 1'b1;
          pend_a_nxt = ins_r ? cur_r[AW-1:0] + AW'(1) : cur_r[AW-1:0] - AW'(1);
          cur_nxt    = ins_r ? cur_r - CW'(1) : cur_r + CW'(1);
          left_nxt   = left_r - CW'(1);
        end else begin
          pend_v_nxt = 1'b0;
          if (!pend_v_r) begin
            // Gap is open or closed: finish the operation.
            if (ins_r) begin
              wr_en     = 1'b1;
              wr_addr   = idx_r;
              wr_data   = val_r;
              count_nxt = count_r + CW'(1);
            end else begin
              count_nxt = count_r - CW'(1);
            end
            out_status_nxt = ST_OK;
            out_elem_nxt   = '0;
            out_last_nxt   = 1'b1;
            out_valid_nxt  = 1'b1;
            state_nxt      = S_OUT;
          end
        end
      end

      S_SEARCH: begin
        // Compare the entry read last cycle while reading the next one.
        if (cmp_v_r && rd_data == val_r) begin
          left_nxt   = count_r - CW'(1) - CW'(cmp_a_r);
          cur_nxt    = CW'(cmp_a_r) + CW'(1);
          ins_nxt    = 1'b0;
          pend_v_nxt = 1'b0;
          state_nxt  = S_MOVE;
        end else if (cmp_v_r && CW'(cmp_a_r) == count_r - CW'(1)) begin
          out_status_nxt = ST_NOT_FOUND;
          out_elem_nxt   = '0;
          out_last_nxt   = 1'b1;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_OUT;
        end else begin
          rd_en     = 1'b1;
          cmp_v_nxt = 1'b1;
          cmp_a_nxt = cur_r[AW-1:0];
          cur_nxt   = cur_r + CW'(1);
        end
      end

      S_RD_LOAD: begin
        // Present one stored element as a result beat.
        out_status_nxt = ST_OK;
        out_elem_nxt   = rd_data;
        out_last_nxt   = (cur_r + CW'(1) == count_r);
        out_valid_nxt  = 1'b1;
        state_nxt      = S_OUT;
      end

      S_OUT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            cur_nxt   = cur_r + CW'(1);
            rd_en     = 1'b1;
            rd_addr   = AW'(cur_r + CW'(1));
            state_nxt = S_RD_LOAD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_v_r    <= 1'b0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_v_r    <= pend_v_nxt;
      cmp_v_r     <= cmp_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r        <= cur_nxt;
    left_r       <= left_nxt;
    ins_r        <= ins_nxt;
    pend_a_r     <= pend_a_nxt;
    cmp_a_r      <= cmp_a_nxt;
    idx_r        <= idx_nxt;
    val_r        <= val_nxt;
    out_status_r <= out_status_nxt;
    out_elem_r   <= out_elem_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Output beat.
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, COUNT_W'(count_r), out_elem_r, out_status_r};

  // Checks on the sequencer.
  `OLE_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CW'(CAPACITY), "count above capacity")
  `OLE_ASSERT_IMP(a_idle_no_result, in_tready, !out_valid_r, "result pending while idle")
  `OLE_ASSERT_IMP(a_err_no_elem, out_valid_r && out_status_r != ST_OK, out_elem_r == '0 && out_last_r, "error beat carries data")
  `OLE_ASSERT_NEXT(a_last_to_idle, out_valid_r && out_tready && out_last_r, in_tready, "not idle after final beat")

endmodule
